// File: src/lucas_kanade_window_flow_assert.svh
// Assertion macros shared by the flow block.
`ifndef LUCAS_KANADE_WINDOW_FLOW_ASSERT_SVH
`define LUCAS_KANADE_WINDOW_FLOW_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds whenever ante holds.
`define LKWF_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkwf check failed");
// Check that cons holds in the cycle after ante.
`define LKWF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkwf check failed");
`else
`define LKWF_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define LKWF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: src/lkwf_pkg.sv
package lkwf_pkg;

    localparam int PIX_W       = 8;
    localparam int SXX_W       = 26;
    localparam int SXY_W       = 27;
    localparam int MIN_DET_W   = 24;
    localparam int MAX_FLOW_W  = 6;
    localparam int FLOW_W      = 15;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;

    localparam logic [MIN_DET_W-1:0]  MIN_DET_RESET  = 24'd500;
    localparam logic [MAX_FLOW_W-1:0] MAX_FLOW_RESET = 6'd24;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DET  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FLOW = 8'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WEAK  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LARGE = 2'd2;

    // serial multiplier: signed a times signed b
    localparam int MUL_A_W   = 56;
    localparam int MUL_B_W   = 27;
    localparam int MUL_ACC_W = MUL_A_W + MUL_B_W;
    localparam int MUL_P_W   = 62;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // restoring divider for the Q6.8 result
    localparam int DIV_Q_W = FLOW_W;
    localparam int DIV_N_W = 66;
    localparam int DIV_D_W = MUL_A_W + 1 + DIV_Q_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        [SXX_W-1:0] sum_xx;
        logic        [SXX_W-1:0] sum_yy;
        logic signed [SXY_W-1:0] sum_xy;
        logic signed [SXY_W-1:0] sum_xt;
        logic signed [SXY_W-1:0] sum_yt;
    } sums_t;

endpackage

// File: src/lkwf_front.sv
module lkwf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // prev_center, prev_left, prev_right, prev_up, prev_down, curr_center
    input  logic [47:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output lkwf_pkg::sums_t      q_push_data
);

    logic signed [lkwf_pkg::PIX_W:0]     gx, gy, it;
    logic signed [2*lkwf_pkg::PIX_W+1:0] pxx, pyy, pxy, pxt, pyt;
    logic                                accept;
    lkwf_pkg::sums_t                     sums_reg, sums_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // gradients, doubled in space
    assign gx = $signed({1'b0, s_tdata[23:16]}) - $signed({1'b0, s_tdata[15:8]});
    assign gy = $signed({1'b0, s_tdata[39:32]}) - $signed({1'b0, s_tdata[31:24]});
    assign it = $signed({1'b0, s_tdata[47:40]}) - $signed({1'b0, s_tdata[7:0]});

    assign pxx = gx * gx;
    assign pyy = gy * gy;
    assign pxy = gx * gy;
    assign pxt = gx * it;
    assign pyt = gy * it;

    // add this pixel, wrapping at the sum widths
    always_comb begin
        sums_next.sum_xx = sums_reg.sum_xx + lkwf_pkg::SXX_W'(pxx);
        sums_next.sum_yy = sums_reg.sum_yy + lkwf_pkg::SXX_W'(pyy);
        sums_next.sum_xy = sums_reg.sum_xy + lkwf_pkg::SXY_W'(pxy);
        sums_next.sum_xt = sums_reg.sum_xt + lkwf_pkg::SXY_W'(pxt);
        sums_next.sum_yt = sums_reg.sum_yt + lkwf_pkg::SXY_W'(pyt);
    end

    assign q_push      = accept && s_tlast;
    assign q_push_data = sums_next;

    // accumulate; hand the window to the queue and clear on the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                sums_reg <= '0;
            end else begin
                sums_reg <= sums_next;
            end
        end
    end

endmodule

// File: src/lkwf_queue.sv
`include "lucas_kanade_window_flow_assert.svh"

module lkwf_queue #(
    parameter int DEPTH = lkwf_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lkwf_pkg::sums_t       push_data,
    input  logic                  pop,
    output lkwf_pkg::sums_t       head,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lkwf_pkg::sums_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // store windows awaiting the solver
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and keep the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `LKWF_ASSERT_NOW(a_no_push_full, aclk, aresetn, push, !full)
    `LKWF_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, pop, !empty)
    `LKWF_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

// File: src/lkwf_mul.sv
module lkwf_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [lkwf_pkg::MUL_A_W-1:0]  a,
    input  logic signed [lkwf_pkg::MUL_B_W-1:0]  b,
    output logic                                 done,
    output logic signed [lkwf_pkg::MUL_P_W-1:0]  p
);

    logic [lkwf_pkg::MUL_A_W-1:0]   a_mag;
    logic [lkwf_pkg::MUL_B_W-1:0]   b_mag;
    logic [lkwf_pkg::MUL_ACC_W-1:0] mcand_reg, acc_reg, acc_next;
    logic [lkwf_pkg::MUL_B_W-1:0]   mplier_reg;
    logic [lkwf_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                           neg_reg, busy_reg, done_reg;

    assign a_mag = a[lkwf_pkg::MUL_A_W-1] ? lkwf_pkg::MUL_A_W'(-a) : lkwf_pkg::MUL_A_W'(a);
    assign b_mag = b[lkwf_pkg::MUL_B_W-1] ? lkwf_pkg::MUL_B_W'(-b) : lkwf_pkg::MUL_B_W'(b);

    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign done = done_reg;
    assign p    = neg_reg ? -$signed(lkwf_pkg::MUL_P_W'(acc_reg))
                          :  $signed(lkwf_pkg::MUL_P_W'(acc_reg));

    // shift and add, one multiplier bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mcand_reg  <= lkwf_pkg::MUL_ACC_W'(a_mag);
                mplier_reg <= b_mag;
                acc_reg    <= '0;
                cnt_reg    <= '0;
                neg_reg    <= a[lkwf_pkg::MUL_A_W-1] ^ b[lkwf_pkg::MUL_B_W-1];
                busy_reg   <= 1'b1;
            end else if (busy_reg) begin
                acc_reg    <= acc_next;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == lkwf_pkg::MUL_CNT_W'(lkwf_pkg::MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/lkwf_back.sv
`include "lucas_kanade_window_flow_assert.svh"

module lkwf_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [lkwf_pkg::MIN_DET_W-1:0]        min_det,
    input  logic [lkwf_pkg::MAX_FLOW_W-1:0]       max_flow,
    input  lkwf_pkg::sums_t                       q_head,
    input  logic                                  q_empty,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // flow_u, flow_v, two zero bits
    output logic [31:0]                           m_tdata,
    // status
    output logic [lkwf_pkg::STATUS_W-1:0]         m_tuser
);

    localparam int DW = lkwf_pkg::MUL_A_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_START, S_MUL_WAIT, S_DIV, S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ST_XXYY, ST_XYXY, ST_YTXY, ST_XTYY, ST_XYXT, ST_XXYT, ST_LIM
    } step_t;

    state_t                                  state_reg;
    step_t                                   step_reg;
    lkwf_pkg::sums_t                         win_reg;
    logic signed [DW-1:0]                    det_reg, nu_reg, nv_reg, det_sub, p_lo;
    logic signed [lkwf_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [lkwf_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [lkwf_pkg::MUL_P_W-1:0]     mul_p;
    logic                                    mul_start, mul_done;
    logic [DW-2:0]                           abs_nu, abs_nv;
    logic                                    weak_tex, too_large;
    logic [lkwf_pkg::DIV_N_W-1:0]            num_reg;
    logic [lkwf_pkg::DIV_D_W-1:0]            dsh_reg;
    logic [lkwf_pkg::DIV_Q_W-1:0]            q_reg, q_next;
    logic [lkwf_pkg::DIV_CNT_W-1:0]          div_cnt_reg;
    logic                                    div_v_reg, div_neg_reg, q_bit;
    logic [lkwf_pkg::FLOW_W-1:0]             res_u_reg, res_v_reg, flow_u_reg, flow_v_reg;
    logic [lkwf_pkg::FLOW_W-1:0]             q_signed;
    logic [lkwf_pkg::STATUS_W-1:0]           res_status_reg, status_reg;
    logic                                    out_valid_reg;

    // operand select for each product of the solve
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_XXYY: begin
                mul_a = DW'(win_reg.sum_xx);
                mul_b = lkwf_pkg::MUL_B_W'(win_reg.sum_yy);
            end
            ST_XYXY: begin
                mul_a = DW'(win_reg.sum_xy);
                mul_b = win_reg.sum_xy;
            end
            ST_YTXY: begin
                mul_a = DW'(win_reg.sum_yt);
                mul_b = win_reg.sum_xy;
            end
            ST_XTYY: begin
                mul_a = DW'(win_reg.sum_xt);
                mul_b = lkwf_pkg::MUL_B_W'(win_reg.sum_yy);
            end
            ST_XYXT: begin
                mul_a = DW'(win_reg.sum_xy);
                mul_b = win_reg.sum_xt;
            end
            ST_XXYT: begin
                mul_a = DW'(win_reg.sum_xx);
                mul_b = win_reg.sum_yt;
            end
            ST_LIM: begin
                mul_a = det_reg;
                mul_b = lkwf_pkg::MUL_B_W'(max_flow);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (state_reg == S_MUL_START);

    lkwf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    assign p_lo      = mul_p[DW-1:0];
    assign det_sub   = det_reg - p_lo;
    assign weak_tex  = (det_sub <= 0) ||
                       (det_sub < $signed({(DW-lkwf_pkg::MIN_DET_W-4)'(0), min_det, 4'b0}));
    assign abs_nu    = nu_reg[DW-1] ? (DW-1)'(-nu_reg) : (DW-1)'(nu_reg);
    assign abs_nv    = nv_reg[DW-1] ? (DW-1)'(-nv_reg) : (DW-1)'(nv_reg);
    assign too_large = (lkwf_pkg::MUL_P_W'({abs_nu, 1'b0}) > lkwf_pkg::MUL_P_W'(mul_p)) ||
                       (lkwf_pkg::MUL_P_W'({abs_nv, 1'b0}) > lkwf_pkg::MUL_P_W'(mul_p));

    // one restoring quotient bit a cycle
    assign q_bit    = ({(lkwf_pkg::DIV_D_W-lkwf_pkg::DIV_N_W)'(0), num_reg} >= dsh_reg);
    assign q_next   = {q_reg[lkwf_pkg::DIV_Q_W-2:0], q_bit};
    assign q_signed = div_neg_reg ? lkwf_pkg::FLOW_W'(-q_next) : q_next;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, flow_v_reg, flow_u_reg};
    assign m_tuser  = status_reg;

    // solve sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_XXYY;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        win_reg   <= q_head;
                        step_reg  <= ST_XXYY;
                        state_reg <= S_MUL_START;
                    end
                end
                S_MUL_START: begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        state_reg <= S_MUL_START;
                        case (step_reg)
                            ST_XXYY: begin
                                det_reg  <= p_lo;
                                step_reg <= ST_XYXY;
                            end
                            ST_XYXY: begin
                                det_reg  <= det_sub;
                                step_reg <= ST_YTXY;
                                if (weak_tex) begin
                                    res_status_reg <= lkwf_pkg::STATUS_WEAK;
                                    state_reg      <= S_FINISH;
                                end
                            end
                            ST_YTXY: begin
                                nu_reg   <= p_lo;
                                step_reg <= ST_XTYY;
                            end
                            ST_XTYY: begin
                                nu_reg   <= nu_reg - p_lo;
                                step_reg <= ST_XYXT;
                            end
                            ST_XYXT: begin
                                nv_reg   <= p_lo;
                                step_reg <= ST_XXYT;
                            end
                            ST_XXYT: begin
                                nv_reg   <= nv_reg - p_lo;
                                step_reg <= ST_LIM;
                            end
                            default: begin
                                if (too_large) begin
                                    res_status_reg <= lkwf_pkg::STATUS_LARGE;
                                    state_reg      <= S_FINISH;
                                end else begin
                                    res_status_reg <= lkwf_pkg::STATUS_OK;
                                    num_reg     <= lkwf_pkg::DIV_N_W'({abs_nu, 10'b0}) +
                                                   lkwf_pkg::DIV_N_W'(det_reg);
                                    dsh_reg     <= {det_reg, 15'b0};
                                    q_reg       <= '0;
                                    div_cnt_reg <= lkwf_pkg::DIV_CNT_W'(lkwf_pkg::DIV_Q_W - 1);
                                    div_neg_reg <= nu_reg[DW-1];
                                    div_v_reg   <= 1'b0;
                                    state_reg   <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (q_bit) begin
                        num_reg <= lkwf_pkg::DIV_N_W'(
                            {(lkwf_pkg::DIV_D_W-lkwf_pkg::DIV_N_W)'(0), num_reg} - dsh_reg);
                    end
                    dsh_reg     <= dsh_reg >> 1;
                    q_reg       <= q_next;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0) begin
                        if (!div_v_reg) begin
                            res_u_reg   <= q_signed;
                            num_reg     <= lkwf_pkg::DIV_N_W'({abs_nv, 10'b0}) +
                                           lkwf_pkg::DIV_N_W'(det_reg);
                            dsh_reg     <= {det_reg, 15'b0};
                            q_reg       <= '0;
                            div_cnt_reg <= lkwf_pkg::DIV_CNT_W'(lkwf_pkg::DIV_Q_W - 1);
                            div_neg_reg <= nv_reg[DW-1];
                            div_v_reg   <= 1'b1;
                        end else begin
                            res_v_reg  <= q_signed;
                            state_reg  <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        if (res_status_reg == lkwf_pkg::STATUS_OK) begin
                            flow_u_reg <= res_u_reg;
                            flow_v_reg <= res_v_reg;
                        end else begin
                            flow_u_reg <= '0;
                            flow_v_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LKWF_ASSERT_NOW(a_zero_unless_ok, aclk, aresetn,
        m_tvalid && (m_tuser != lkwf_pkg::STATUS_OK), (m_tdata == '0))
    `LKWF_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid,
        (m_tuser == lkwf_pkg::STATUS_OK) || (m_tuser == lkwf_pkg::STATUS_WEAK) ||
        (m_tuser == lkwf_pkg::STATUS_LARGE))
    `LKWF_ASSERT_NEXT(a_pop_starts_solve, aclk, aresetn, q_pop, state_reg == S_MUL_START)

endmodule

// File: src/lucas_kanade_window_flow.sv
// Lucas-Kanade flow for one window. Pixels enter at one word per cycle while tready is high; the
// front adds each pixel into five structure sums that wrap at their widths and, on the word
// marked tlast, hands the window to a two-entry queue. The back solves a queued window with one
// shared bit-serial multiplier (seven products) and a bit-serial divider (two quotients); that
// multiplier loop sets the window rate. Windows that take longer to stream in than a solve
// stream without stall; shorter ones hold tready low once both queue entries wait.
// Results give flow_u and flow_v in signed Q6.8 and a status: ok, weak texture, or
// displacement too large.
module lucas_kanade_window_flow #(
    parameter int QUEUE_DEPTH = lkwf_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // prev_center, prev_left, prev_right, prev_up, prev_down, curr_center
    input  logic [47:0]                        s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // flow_u, flow_v, two zero bits
    output logic [31:0]                        m_tdata,
    // status
    output logic [lkwf_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkwf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lkwf_pkg::MIN_DET_W-1:0]     cfg_data
);

    logic [lkwf_pkg::MIN_DET_W-1:0]  min_det_reg;
    logic [lkwf_pkg::MAX_FLOW_W-1:0] max_flow_reg;
    lkwf_pkg::sums_t                 push_data, head;
    logic                            q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_det_reg  <= lkwf_pkg::MIN_DET_RESET;
            max_flow_reg <= lkwf_pkg::MAX_FLOW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lkwf_pkg::CFG_MIN_DET:  min_det_reg  <= cfg_data;
                lkwf_pkg::CFG_MAX_FLOW: max_flow_reg <= cfg_data[lkwf_pkg::MAX_FLOW_W-1:0];
                default: ;
            endcase
        end
    end

    lkwf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (push_data)
    );

    lkwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    lkwf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .min_det  (min_det_reg),
        .max_flow (max_flow_reg),
        .q_head   (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: dv/lkwf_checker.sv
module lkwf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [lkwf_pkg::STATUS_W-1:0] m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [lkwf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lkwf_pkg::MIN_DET_W-1:0]   cfg_data,
    output int          fail_count,
    output int          flows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lkwf_pkg::FLOW_W-1:0]   u;
        logic [lkwf_pkg::FLOW_W-1:0]   v;
        logic [lkwf_pkg::STATUS_W-1:0] status;
    } flow_t;

    flow_t expected_flows[$];
    logic [lkwf_pkg::MIN_DET_W-1:0]  det_floor;
    logic [lkwf_pkg::MAX_FLOW_W-1:0] flow_limit;
    longint acc_xx, acc_yy, acc_xy, acc_xt, acc_yt;

    function automatic longint wrap_signed27(longint x);
        logic [26:0] m;
        m = x[26:0];
        return longint'($signed(m));
    endfunction

    // round 256*num/den to nearest, ties away from zero
    function automatic longint round_q8(longint num, longint den);
        longint a;
        longint q;
        a = num < 0 ? -num : num;
        q = (a * 512 + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    // accumulate one pixel; solve and clear on the last one
    task automatic add_pixel(input logic [47:0] w, input logic last);
        longint gx, gy, dt, det, nu, nv, au, av, lim;
        flow_t f;
        gx = longint'(w[23:16]) - longint'(w[15:8]);
        gy = longint'(w[39:32]) - longint'(w[31:24]);
        dt = longint'(w[47:40]) - longint'(w[7:0]);
        acc_xx = (acc_xx + gx * gx) & 64'h3FF_FFFF;
        acc_yy = (acc_yy + gy * gy) & 64'h3FF_FFFF;
        acc_xy = wrap_signed27(acc_xy + gx * gy);
        acc_xt = wrap_signed27(acc_xt + gx * dt);
        acc_yt = wrap_signed27(acc_yt + gy * dt);
        if (last) begin
            f.u = '0;
            f.v = '0;
            det = acc_xx * acc_yy - acc_xy * acc_xy;
            if (det <= 0 || det < 16 * longint'(det_floor)) begin
                f.status = lkwf_pkg::STATUS_WEAK;
            end else begin
                nu = acc_yt * acc_xy - acc_xt * acc_yy;
                nv = acc_xy * acc_xt - acc_xx * acc_yt;
                au = nu < 0 ? -nu : nu;
                av = nv < 0 ? -nv : nv;
                lim = longint'(flow_limit) * det;
                if (2 * au > lim || 2 * av > lim) begin
                    f.status = lkwf_pkg::STATUS_LARGE;
                end else begin
                    f.status = lkwf_pkg::STATUS_OK;
                    f.u = lkwf_pkg::FLOW_W'(round_q8(2 * nu, det));
                    f.v = lkwf_pkg::FLOW_W'(round_q8(2 * nv, det));
                end
            end
            expected_flows.push_back(f);
            acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_xt = 0; acc_yt = 0;
        end
    endtask

    always @(posedge aclk) begin
        flow_t e;
        if (!aresetn) begin
            det_floor  <= lkwf_pkg::MIN_DET_RESET;
            flow_limit <= lkwf_pkg::MAX_FLOW_RESET;
            acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_xt = 0; acc_yt = 0;
            expected_flows.delete();
            fail_count <= 0;
        end else begin
            // compare each result word with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_flows.size() == 0) begin
                    $display("%0t: unexpected result %h status %0d", $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_flows.pop_front();
                    if (m_tdata[14:0] !== e.u || m_tdata[29:15] !== e.v
                        || m_tuser !== e.status) begin
                        $display("%0t: expected u %h v %h status %0d, got u %h v %h status %0d",
                                 $time, e.u, e.v, e.status,
                                 m_tdata[14:0], m_tdata[29:15], m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) add_pixel(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lkwf_pkg::CFG_MIN_DET) det_floor <= cfg_data;
                else if (cfg_index == lkwf_pkg::CFG_MAX_FLOW)
                    flow_limit <= cfg_data[lkwf_pkg::MAX_FLOW_W-1:0];
            end
        end
        flows_pending = expected_flows.size();
    end
endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [lkwf_pkg::STATUS_W-1:0] m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [lkwf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lkwf_pkg::MIN_DET_W-1:0]   cfg_data = '0;
    int          fail_count;
    int          flows_pending;
    bit          steady = 0;

    always #1 aclk = ~aclk;

    lucas_kanade_window_flow dut (.*);

    lkwf_checker u_checker (.*);

    // receiver stalls at random, none while steady
    always @(negedge aclk) m_tready <= steady || ($urandom_range(99) >= 38);

    task automatic write_reg(input logic [lkwf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lkwf_pkg::MIN_DET_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_pixel(input logic [47:0] w, input logic last);
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait for all results, then let the solver settle
    task automatic drain();
        s_tvalid <= 0;
        while (flows_pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // one window: a moving gradient pattern with noise, shift picked at random
    task automatic send_window(input int n, input int noise);
        int dx, dy, k, x, y, a, b, c;
        logic [47:0] w;
        dx = $urandom_range(6) - 3;
        dy = $urandom_range(6) - 3;
        a = $urandom_range(12) + 1;
        b = $urandom_range(12) + 1;
        for (k = 0; k < n; k++) begin
            x = k % 5; y = k / 5;
            c = 60 + a * x + b * y + ((x * y * 7) % 11);
            w[7:0]   = 8'(c);
            w[15:8]  = 8'(c - a);
            w[23:16] = 8'(c + a + $urandom_range(noise));
            w[31:24] = 8'(c - b);
            w[39:32] = 8'(c + b + $urandom_range(noise));
            w[47:40] = 8'(c - (a * dx + b * dy) / 2 + $urandom_range(noise));
            if ($urandom_range(9) == 0) w = 48'({$urandom, $urandom});
            send_pixel(w, k == n - 1);
        end
    endtask

    initial begin
        int i, n;
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: extremes, flat window, single-pixel window
        send_pixel('0, 1);
        send_pixel({48{1'b1}}, 1);
        send_pixel({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00}, 0);
        send_pixel({8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF}, 1);
        for (i = 0; i < 6; i++) send_pixel({8'd0, 8'd200, 8'd0, 8'd0, 8'd200, 8'd100}, i == 5);
        send_window(9, 0);
        send_window(12, 3);
        drain();
        write_reg(lkwf_pkg::CFG_MIN_DET, '0);
        write_reg(lkwf_pkg::CFG_MAX_FLOW, '1);
        send_window(9, 0);
        send_window(15, 60);
        drain();
        write_reg(lkwf_pkg::CFG_MAX_FLOW, '0);
        write_reg(lkwf_pkg::CFG_MIN_DET, '1);
        send_window(10, 2);
        send_window(10, 200);
        drain();
        write_reg(lkwf_pkg::CFG_MIN_DET, 24'd20);
        write_reg(lkwf_pkg::CFG_MAX_FLOW, 24'd2);
        // random windows, including some long ones
        n = 0;
        while (n < 375) begin
            if (n > 150 && n < 250) steady = 1;
            else steady = 0;
            i = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 4);
            send_window(i, $urandom_range(1) ? 0 : $urandom_range(255));
            n += i;
            if (n > 300 && n < 320) begin
                drain();
                write_reg(lkwf_pkg::CFG_MIN_DET, 24'($urandom_range(2000)));
                write_reg(lkwf_pkg::CFG_MAX_FLOW, 24'($urandom_range(63)));
            end
        end
        drain();
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
